### rtl/core/siafo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siafo_pkg: shared types and constants
// Operation codes, data width and the control bundle between sequencer and
// datapath of the five-operation integer unit.
// ----------------------------------------------------------------------------
package siafo_pkg;

  localparam int DataWidth = 32;
  localparam int CntWidth  = $clog2(DataWidth + 1);

  typedef logic [2:0] cmd_t;
  typedef logic [DataWidth-1:0] word_t;
  typedef logic [CntWidth-1:0] cnt_t;

  localparam cmd_t OpAdd = 3'd0;
  localparam cmd_t OpSub = 3'd1;
  localparam cmd_t OpMul = 3'd2;
  localparam cmd_t OpDiv = 3'd3;
  localparam cmd_t OpMod = 3'd4;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFix,
    StOut
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic fix;
  } ctrl_t;

endpackage

### rtl/core/siafo_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siafo_datapath: bit-serial arithmetic datapath
// One operand bit per step: ripple add/sub, shift-add multiply and restoring
// shift-subtract divide on magnitudes, followed by a sign fix.
// ----------------------------------------------------------------------------
module siafo_datapath (
  input  logic             clk_i,
  input  siafo_pkg::ctrl_t ctrl_i,
  input  siafo_pkg::cmd_t  command_i,
  input  siafo_pkg::word_t left_operand_i,
  input  siafo_pkg::word_t right_operand_i,
  output siafo_pkg::word_t result_o
);
  import siafo_pkg::*;

  cmd_t  cmd_q;
  word_t a_q, b_q, acc_q, res_q;
  logic  carry_q, neg_q, zero_q;
  word_t a_d, b_d, acc_d, res_d;
  logic  carry_d, neg_d, zero_d;

  logic [DataWidth:0] trial;
  logic bs, sum_bit, sum_c;
  word_t ma, mb;

  always_comb begin
    ma = left_operand_i[DataWidth-1] ? (~left_operand_i + 1'b1) : left_operand_i;
    mb = right_operand_i[DataWidth-1] ? (~right_operand_i + 1'b1) : right_operand_i;
    bs      = (cmd_q == OpSub) ? ~b_q[0] : b_q[0];
    sum_bit = a_q[0] ^ bs ^ carry_q;
    sum_c   = (a_q[0] & bs) | (a_q[0] & carry_q) | (bs & carry_q);
    trial   = {acc_q, a_q[DataWidth-1]} - {1'b0, b_q};
    a_d = a_q; b_d = b_q; acc_d = acc_q; res_d = res_q;
    carry_d = carry_q; neg_d = neg_q; zero_d = zero_q;
    if (ctrl_i.load) begin
      carry_d = (command_i == OpSub);
      zero_d  = (right_operand_i == '0);
      acc_d   = '0;
      case (command_i)
        OpDiv: begin
          a_d = ma; b_d = mb;
          neg_d = left_operand_i[DataWidth-1] ^ right_operand_i[DataWidth-1];
        end
        OpMod: begin
          a_d = ma; b_d = mb; neg_d = left_operand_i[DataWidth-1];
        end
        default: begin
          a_d = left_operand_i; b_d = right_operand_i; neg_d = 1'b0;
        end
      endcase
    end else if (ctrl_i.step) begin
      case (cmd_q)
        OpAdd, OpSub: begin
          a_d = a_q >> 1; b_d = b_q >> 1; carry_d = sum_c;
          acc_d = {sum_bit, acc_q[DataWidth-1:1]};
        end
        OpMul: begin
          if (b_q[0]) acc_d = acc_q + a_q;
          a_d = a_q << 1; b_d = b_q >> 1;
        end
        OpDiv, OpMod: begin
          if (!trial[DataWidth]) begin
            acc_d = trial[DataWidth-1:0];
            a_d   = {a_q[DataWidth-2:0], 1'b1};
          end else begin
            acc_d = {acc_q[DataWidth-2:0], a_q[DataWidth-1]};
            a_d   = {a_q[DataWidth-2:0], 1'b0};
          end
        end
        default: ;
      endcase
    end else if (ctrl_i.fix) begin
      case (cmd_q)
        OpAdd, OpSub, OpMul: res_d = acc_q;
        OpDiv: res_d = zero_q ? '0 : (neg_q ? (~a_q + 1'b1) : a_q);
        OpMod: res_d = zero_q ? '0 : (neg_q ? (~acc_q + 1'b1) : acc_q);
        default: res_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) cmd_q <= command_i;
    a_q <= a_d; b_q <= b_d; acc_q <= acc_d; res_q <= res_d;
    carry_q <= carry_d; neg_q <= neg_d; zero_q <= zero_d;
  end

  assign result_o = res_q;
endmodule

### rtl/core/siafo_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siafo_seq: item sequencer
// Loads an item, counts one step per operand bit, fixes the sign and holds
// the result until taken.
// ----------------------------------------------------------------------------
module siafo_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output siafo_pkg::ctrl_t ctrl_o
);
  import siafo_pkg::*;

  state_e state_q, state_d;
  cnt_t   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctrl_o  = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          cnt_d   = '0;
          state_d = StRun;
        end
      end
      StRun: begin
        ctrl_o.step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == cnt_t'(DataWidth - 1)) state_d = StFix;
      end
      StFix: begin
        ctrl_o.fix = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
endmodule

### rtl/core/signed_int_alu_five_ops_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_alu_five_ops_unit: bit-serial signed add/sub/mul/div/mod
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   command, left_operand, right_operand
//   out      output     out_valid/out_stall result_value
//
// one item goes through load, one step per operand bit and a sign fix,
// then the result is offered.
// one item in flight; a new item is taken once the result has been taken.
// reset clears the sequencer only; out_stall holds the result in place.
// ----------------------------------------------------------------------------
module signed_int_alu_five_ops_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  siafo_pkg::cmd_t  command_i,
  input  siafo_pkg::word_t left_operand_i,
  input  siafo_pkg::word_t right_operand_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output siafo_pkg::word_t result_value_o
);
  import siafo_pkg::*;

  ctrl_t ctrl;

  siafo_seq u_seq (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .ctrl_o(ctrl)
  );

  siafo_datapath u_dp (
    .clk_i, .ctrl_i(ctrl), .command_i, .left_operand_i, .right_operand_i,
    .result_o(result_value_o)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept while result pending");
  a_out_after_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctrl.fix)) else $error("result without fix");
  a_one_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ctrl)) else $error("control overlap");
endmodule
